### src/sobel_edge_magnitude_rgb_top_assert.svh
// Assertion macros for the Sobel edge magnitude block.
// Included by the top level; needs a clock and an active-high reset argument.
`ifndef SOBEL_EDGE_MAGNITUDE_RGB_TOP_ASSERT_SVH
`define SOBEL_EDGE_MAGNITUDE_RGB_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SEM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SEM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/sem_pkg.sv
// Shared constants and types for the Sobel edge magnitude block.
// No dependencies; referenced by scoped names from the top level.
package sem_pkg;

  // Line store depth default.
  localparam int DEFAULT_MAX_WIDTH = 2048;

  // Pixel layout: three 8-bit channels, red in the top byte internally.
  localparam int CH_W     = 8;
  localparam int CHANNELS = 3;
  localparam int PIX_W    = CH_W * CHANNELS;

  typedef logic [PIX_W-1:0] pixel_t;
  typedef logic [CH_W-1:0]  chan_t;

  // Configuration register widths, reset values and indexes.
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 16;
  localparam int FW_W       = 12;
  localparam int FH_W       = 16;

  localparam logic [FW_W-1:0] FRAME_WIDTH_RESET  = 12'd640;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RESET = 16'd480;

  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_HEIGHT = 1'd1;

  // Smallest frame dimension the window logic supports.
  localparam int MIN_DIM = 3;

  // Squared magnitude at which the output saturates (255 * 255).
  localparam logic [16:0] MAG_SAT_SQ = 17'd65025;
  localparam chan_t       MAG_MAX    = 8'd255;

endpackage

### src/sem_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies; used for the line stores of the Sobel block.
module sem_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; data holds while re is low.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/sobel_edge_magnitude_rgb_top.sv
// Sobel edge magnitude on an RGB raster stream, one 3x3 window per interior pixel.
// Depends on sem_pkg, sem_ram and sobel_edge_magnitude_rgb_top_assert.svh.
//
// Pixels enter in raster order and the block sustains one pixel per clock when not
// stalled: the two line stores are RAMs with one read and one write port each, read
// at the incoming column and written back from stage 1, so each port is used once
// per pixel. A result passes stage 1 to stage 4, then the output register, after the
// transaction completing its window; stage 4 and the output register split the root.
// Input and pipeline stall together only while a result waits in the output register.
// Pixels of the first two rows and first two columns give no transaction; tlast marks
// the last interior pixel of the frame. The line stores need no clearing after reset,
// and frame_width/frame_height may be written only while the block is idle.
`include "sobel_edge_magnitude_rgb_top_assert.svh"

module sobel_edge_magnitude_rgb_top #(
  parameter int MAX_WIDTH = sem_pkg::DEFAULT_MAX_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst,
  // Configuration write port.
  input  logic                            cfg_we,
  input  logic [sem_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [sem_pkg::CFG_DATA_W-1:0]  cfg_data,
  // Pixel input stream.
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [23:0]                     s_axis_tdata,  // in_red, in_green, in_blue
  // Edge magnitude output stream.
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [23:0]                     m_axis_tdata,  // edge_red, edge_green, edge_blue
  output logic                            m_axis_tlast   // frame_done
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int EW_W  = (COL_W + 1 > sem_pkg::FW_W) ? COL_W + 1 : sem_pkg::FW_W;
  localparam int FH_W  = sem_pkg::FH_W;

  // Partial square root: running remainder and root bits found so far.
  typedef struct packed {
    logic [10:0]    rem;
    sem_pkg::chan_t root;
  } root_part_t;

  // Channel ch of a pixel, red first (red sits in the top byte).
  function automatic sem_pkg::chan_t chan(input sem_pkg::pixel_t p, input int ch);
    return p[sem_pkg::CH_W*(sem_pkg::CHANNELS-1-ch) +: sem_pkg::CH_W];
  endfunction

  // Four steps of the floor square root, one result bit per pair of input bits.
  function automatic root_part_t isqrt_half(input root_part_t part, input logic [7:0] bits);
    root_part_t  p;
    logic [10:0] trial;
    p = part;
    for (int i = 3; i >= 0; i--) begin
      p.rem = {p.rem[8:0], bits[2*i +: 2]};
      trial = {1'b0, p.root, 2'b01};
      if (p.rem >= trial) begin
        p.rem  = p.rem - trial;
        p.root = {p.root[6:0], 1'b1};
      end else begin
        p.root = {p.root[6:0], 1'b0};
      end
    end
    return p;
  endfunction

  // Configuration registers.
  logic [sem_pkg::FW_W-1:0] frame_width;
  logic [FH_W-1:0]          frame_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= sem_pkg::FRAME_WIDTH_RESET;
      frame_height <= sem_pkg::FRAME_HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        sem_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data[sem_pkg::FW_W-1:0];
        sem_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data[FH_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: every stage moves when the output register can take a result.
  logic adv;
  logic in_accept;
  logic out_valid;

  assign adv           = !out_valid || m_axis_tready;
  assign s_axis_tready = adv;
  assign in_accept     = s_axis_tvalid && adv;

  // Effective frame size.
  logic [EW_W-1:0] fw_ext;
  logic [EW_W-1:0] eff_width;
  logic [EW_W-1:0] last_col;
  logic [FH_W-1:0] eff_height;
  logic [FH_W-1:0] last_row;

  always_comb begin
    fw_ext = EW_W'(frame_width);
    if (fw_ext < EW_W'(sem_pkg::MIN_DIM)) begin
      eff_width = EW_W'(sem_pkg::MIN_DIM);
    end else if (fw_ext > EW_W'(MAX_WIDTH)) begin
      eff_width = EW_W'(MAX_WIDTH);
    end else begin
      eff_width = fw_ext;
    end
    last_col = eff_width - EW_W'(1);
    if (frame_height < FH_W'(sem_pkg::MIN_DIM)) begin
      eff_height = FH_W'(sem_pkg::MIN_DIM);
    end else begin
      eff_height = frame_height;
    end
    last_row = eff_height - FH_W'(1);
  end

  // Raster position of the incoming pixel.
  logic [COL_W-1:0] col_cnt;
  logic [COL_W-1:0] col_cnt_next;
  logic [FH_W-1:0]  row_cnt;
  logic [FH_W-1:0]  row_cnt_next;
  logic             row_end;
  logic             frame_end;
  logic             emit;

  assign row_end   = EW_W'(col_cnt) >= last_col;
  assign frame_end = row_end && (row_cnt >= last_row);
  assign emit      = (col_cnt >= COL_W'(2)) && (row_cnt >= FH_W'(2));

  always_comb begin
    if (row_end) begin
      col_cnt_next = '0;
      row_cnt_next = frame_end ? '0 : row_cnt + FH_W'(1);
    end else begin
      col_cnt_next = col_cnt + COL_W'(1);
      row_cnt_next = row_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (in_accept) begin
      col_cnt <= col_cnt_next;
      row_cnt <= row_cnt_next;
    end
  end

  // Incoming pixel, repacked with red in the top byte.
  sem_pkg::pixel_t in_pix;
  assign in_pix = {s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16]};

  // Stage 1: line store read data arrives; window is assembled and written back.
  logic             s1_valid;
  logic             s1_emit;
  logic             s1_last;
  logic [COL_W-1:0] s1_idx;
  sem_pkg::pixel_t  s1_pix;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_emit <= emit;
      s1_last <= frame_end;
      s1_idx  <= col_cnt;
      s1_pix  <= in_pix;
    end
  end

  // Line stores. Read and write-back addresses of neighboring pixels always differ
  // (a frame row is at least three pixels), so no forwarding is needed.
  logic            wb_en;
  sem_pkg::pixel_t upper_rd;
  sem_pkg::pixel_t middle_rd;

  assign wb_en = s1_valid && adv;

  sem_ram #(
    .WIDTH (sem_pkg::PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_upper_line (
    .clk   (clk),
    .we    (wb_en),
    .waddr (s1_idx),
    .wdata (middle_rd),
    .re    (in_accept),
    .raddr (col_cnt),
    .rdata (upper_rd)
  );

  sem_ram #(
    .WIDTH (sem_pkg::PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_middle_line (
    .clk   (clk),
    .we    (wb_en),
    .waddr (s1_idx),
    .wdata (s1_pix),
    .re    (in_accept),
    .raddr (col_cnt),
    .rdata (middle_rd)
  );

  // Window columns c-2 (win_a) and c-1 (win_b), rows top to bottom.
  sem_pkg::pixel_t win_a [3];
  sem_pkg::pixel_t win_b [3];
  sem_pkg::pixel_t win_c [3];

  assign win_c[0] = upper_rd;
  assign win_c[1] = middle_rd;
  assign win_c[2] = s1_pix;

  always_ff @(posedge clk) begin
    if (wb_en) begin
      for (int l = 0; l < 3; l++) begin
        win_a[l] <= win_b[l];
        win_b[l] <= win_c[l];
      end
    end
  end

  // Gradients per channel: vertical (bottom minus top) and horizontal (right minus
  // left), each weighted 1-2-1, then clamped to 0..255.
  sem_pkg::chan_t grad_v [sem_pkg::CHANNELS];
  sem_pkg::chan_t grad_h [sem_pkg::CHANNELS];

  always_comb begin
    logic [9:0]         top_s;
    logic [9:0]         bot_s;
    logic [9:0]         lft_s;
    logic [9:0]         rgt_s;
    logic signed [11:0] dv;
    logic signed [11:0] dh;
    for (int ch = 0; ch < sem_pkg::CHANNELS; ch++) begin
      top_s = 10'(chan(win_a[0], ch)) + {1'b0, chan(win_b[0], ch), 1'b0}
            + 10'(chan(win_c[0], ch));
      bot_s = 10'(chan(win_a[2], ch)) + {1'b0, chan(win_b[2], ch), 1'b0}
            + 10'(chan(win_c[2], ch));
      lft_s = 10'(chan(win_a[0], ch)) + {1'b0, chan(win_a[1], ch), 1'b0}
            + 10'(chan(win_a[2], ch));
      rgt_s = 10'(chan(win_c[0], ch)) + {1'b0, chan(win_c[1], ch), 1'b0}
            + 10'(chan(win_c[2], ch));
      dv = $signed({2'b00, bot_s}) - $signed({2'b00, top_s});
      dh = $signed({2'b00, rgt_s}) - $signed({2'b00, lft_s});
      if (dv < 0) begin
        grad_v[ch] = '0;
      end else if (dv > 12'sd255) begin
        grad_v[ch] = sem_pkg::MAG_MAX;
      end else begin
        grad_v[ch] = dv[7:0];
      end
      if (dh < 0) begin
        grad_h[ch] = '0;
      end else if (dh > 12'sd255) begin
        grad_h[ch] = sem_pkg::MAG_MAX;
      end else begin
        grad_h[ch] = dh[7:0];
      end
    end
  end

  // Stage 2: clamped gradients of interior pixels only.
  logic           s2_valid;
  logic           s2_last;
  sem_pkg::chan_t s2_gv [sem_pkg::CHANNELS];
  sem_pkg::chan_t s2_gh [sem_pkg::CHANNELS];

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid && s1_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_last <= s1_last;
      for (int ch = 0; ch < sem_pkg::CHANNELS; ch++) begin
        s2_gv[ch] <= grad_v[ch];
        s2_gh[ch] <= grad_h[ch];
      end
    end
  end

  // Stage 3: sum of squares.
  logic        s3_valid;
  logic        s3_last;
  logic [16:0] s3_sum [sem_pkg::CHANNELS];

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (adv) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_last <= s2_last;
      for (int ch = 0; ch < sem_pkg::CHANNELS; ch++) begin
        s3_sum[ch] <= 17'(16'(s2_gv[ch]) * 16'(s2_gv[ch]))
                    + 17'(16'(s2_gh[ch]) * 16'(s2_gh[ch]));
      end
    end
  end

  // Stage 4: saturation flag and the upper four bits of the square root.
  logic           s4_valid;
  logic           s4_last;
  logic           s4_sat  [sem_pkg::CHANNELS];
  root_part_t     s4_part [sem_pkg::CHANNELS];
  logic [7:0]     s4_low  [sem_pkg::CHANNELS];

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (adv) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_last <= s3_last;
      for (int ch = 0; ch < sem_pkg::CHANNELS; ch++) begin
        s4_sat[ch]  <= s3_sum[ch] >= sem_pkg::MAG_SAT_SQ;
        s4_part[ch] <= isqrt_half('0, s3_sum[ch][15:8]);
        s4_low[ch]  <= s3_sum[ch][7:0];
      end
    end
  end

  // Lower four bits of the square root.
  root_part_t root_fin [sem_pkg::CHANNELS];

  always_comb begin
    for (int ch = 0; ch < sem_pkg::CHANNELS; ch++) begin
      root_fin[ch] = isqrt_half(s4_part[ch], s4_low[ch]);
    end
  end

  // Output register: saturated integer square root.
  logic           out_last;
  sem_pkg::chan_t out_mag [sem_pkg::CHANNELS];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_last <= s4_last;
      for (int ch = 0; ch < sem_pkg::CHANNELS; ch++) begin
        if (s4_sat[ch]) begin
          out_mag[ch] <= sem_pkg::MAG_MAX;
        end else begin
          out_mag[ch] <= root_fin[ch].root;
        end
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_mag[2], out_mag[1], out_mag[0]};
  assign m_axis_tlast  = out_last;

  // Checks on pipeline and counter behavior.
  `SEM_ASSERT_NEXT(a_frame_wrap, clk, rst, in_accept && frame_end, (col_cnt == '0) && (row_cnt == '0), "counters did not wrap at frame end")
  `SEM_ASSERT_NEXT(a_stall_hold, clk, rst, s1_valid && !adv, s1_valid && $stable(s1_idx), "stage 1 moved during a stall")
  `SEM_ASSERT_NOW(a_no_rw_clash, clk, rst, wb_en && in_accept, s1_idx != col_cnt, "line store read and write-back hit the same entry")
  `SEM_ASSERT_NOW(a_out_source, clk, rst, $rose(out_valid), $past(s4_valid), "result appeared without a stage 4 item")

endmodule

### tb/tb.sv
// Self-checking testbench for the Sobel edge magnitude block on an RGB raster stream.
// Depends on sem_pkg and sobel_edge_magnitude_rgb_top; a built-in model predicts each edge pixel.
// Frames of several sizes are streamed with random gaps on both buses, and results are checked in order.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HALF_PERIOD   = 6;
  localparam int RESET_CYCLES  = 7;
  localparam int LINE_DEPTH    = sem_pkg::DEFAULT_MAX_WIDTH;
  localparam int SETTLE_CYCLES = 10;
  localparam int HOLD_CYCLES   = 400;
  localparam int STALL_LIMIT   = 2000;
  localparam int RANDOM_PIXELS = 900;
  localparam int IDLE_PERCENT  = 33;

  localparam int CH_RED   = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 2;

  // Pixel as it travels in tdata: red in the lowest byte.
  typedef struct packed {
    sem_pkg::chan_t blue;
    sem_pkg::chan_t green;
    sem_pkg::chan_t red;
  } rgb_t;

  // Edge result as {tlast, tdata}.
  typedef struct packed {
    logic           done;
    sem_pkg::chan_t blue;
    sem_pkg::chan_t green;
    sem_pkg::chan_t red;
  } edge_t;

  typedef enum {STYLE_NOISE, STYLE_SMOOTH, STYLE_SPARSE, STYLE_ROWS, STYLE_COLS} style_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_we = 1'b0;
  logic [sem_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [sem_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [23:0]                    s_axis_tdata = '0;  // in_red, in_green, in_blue
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [23:0]                    m_axis_tdata;       // edge_red, edge_green, edge_blue
  logic                           m_axis_tlast;       // frame_done

  sobel_edge_magnitude_rgb_top DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #HALF_PERIOD clk = ~clk;

  // Shadow copy of the block's registers and window state.
  logic [sem_pkg::FW_W-1:0] width_reg  = sem_pkg::FRAME_WIDTH_RESET;
  logic [sem_pkg::FH_W-1:0] height_reg = sem_pkg::FRAME_HEIGHT_RESET;
  rgb_t        upper_row [LINE_DEPTH];
  rgb_t        middle_row [LINE_DEPTH];
  rgb_t        win_hist [3][2];  // [row][column], column 0 is two pixels back
  logic [10:0] col_pos = '0;
  logic [15:0] row_pos = '0;

  rgb_t  pending_pixels [$];
  edge_t expected_edges [$];

  int    mismatches = 0;
  int    stall_left = 0;
  bit    no_idle = 1'b0;
  int    idle_cycles = 0;
  int    cur_w, cur_h;
  int    tone_base, slope_x, slope_y;
  edge_t got_edge, want_edge;

  function automatic int channel_of(rgb_t p, int ch);
    case (ch)
      CH_RED:   return p.red;
      CH_GREEN: return p.green;
      default:  return p.blue;
    endcase
  endfunction

  // Gradients are clamped to 0..255 before the root; the root saturates at 255.
  function automatic int edge_magnitude(int gx, int gy);
    int sq, root;
    gx = (gx < 0) ? 0 : (gx > 255) ? 255 : gx;
    gy = (gy < 0) ? 0 : (gy > 255) ? 255 : gy;
    sq = gx * gx + gy * gy;
    root = 0;
    while (root < 255 && (root + 1) * (root + 1) <= sq) root++;
    return root;
  endfunction

  // Advances the window by one accepted pixel and queues the edge result it completes.
  function automatic void compute_edge_pixel(rgb_t pix);
    rgb_t  w [3][3];  // [column][row]; column 2 and row 2 hold the incoming pixel
    int    v [3][3];
    int    mag [3];
    int    ew, eh, ch, k, l, gx, gy;
    logic  row_end, frame_end;
    edge_t res;
    ew = (width_reg < 3) ? 3 : (width_reg > LINE_DEPTH) ? LINE_DEPTH : width_reg;
    eh = (height_reg < 3) ? 3 : height_reg;
    for (l = 0; l < 3; l++) begin
      w[0][l] = win_hist[l][0];
      w[1][l] = win_hist[l][1];
    end
    w[2][0] = upper_row[col_pos];
    w[2][1] = middle_row[col_pos];
    w[2][2] = pix;
    row_end = (col_pos >= ew - 1);
    frame_end = row_end && (row_pos >= eh - 1);

    if (col_pos >= 2 && row_pos >= 2) begin
      for (ch = 0; ch < 3; ch++) begin
        for (k = 0; k < 3; k++)
          for (l = 0; l < 3; l++)
            v[k][l] = channel_of(w[k][l], ch);
        gx = v[0][2] - v[0][0] + 2 * (v[1][2] - v[1][0]) + v[2][2] - v[2][0];
        gy = v[2][0] - v[0][0] + 2 * (v[2][1] - v[0][1]) + v[2][2] - v[0][2];
        mag[ch] = edge_magnitude(gx, gy);
      end
      res.red   = 8'(mag[CH_RED]);
      res.green = 8'(mag[CH_GREEN]);
      res.blue  = 8'(mag[CH_BLUE]);
      res.done  = frame_end;
      expected_edges.push_back(res);
    end

    upper_row[col_pos]  = w[2][1];
    middle_row[col_pos] = pix;
    for (l = 0; l < 3; l++) begin
      win_hist[l][0] = w[1][l];
      win_hist[l][1] = w[2][l];
    end
    if (row_end) begin
      col_pos = '0;
      row_pos = frame_end ? '0 : row_pos + 1'b1;
    end else begin
      col_pos = col_pos + 1'b1;
    end
  endfunction

  function automatic void flag_mismatch(string field, int want_v, int got_v);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want_v, got_v);
    mismatches++;
  endfunction

  function automatic rgb_t make_pixel(style_t style, int x, int y);
    rgb_t p;
    int   lvl [3];
    int   ch;
    case (style)
      STYLE_ROWS: begin
        lvl[CH_RED]   = (y >= 2) ? 255 : 0;
        lvl[CH_GREEN] = (y == 0) ? 255 : 0;
        lvl[CH_BLUE]  = 128;
      end
      STYLE_COLS: begin
        lvl[CH_RED]   = (x == 0) ? 255 : 0;
        lvl[CH_GREEN] = (x >= 2) ? 255 : 0;
        lvl[CH_BLUE]  = 255;
      end
      default: begin
        for (ch = 0; ch < 3; ch++) begin
          if (style == STYLE_NOISE)
            lvl[ch] = $urandom_range(0, 255);
          else if (style == STYLE_SMOOTH)
            lvl[ch] = tone_base + ch * 29 + x * slope_x + y * slope_y
                      + int'($urandom_range(0, 4)) - 2;
          else if ($urandom_range(0, 7) == 0)
            lvl[ch] = $urandom_range(0, 1) ? 255 : 0;
          else
            lvl[ch] = tone_base;
        end
      end
    endcase
    for (ch = 0; ch < 3; ch++)
      lvl[ch] = (lvl[ch] < 0) ? 0 : (lvl[ch] > 255) ? 255 : lvl[ch];
    p.red   = 8'(lvl[CH_RED]);
    p.green = 8'(lvl[CH_GREEN]);
    p.blue  = 8'(lvl[CH_BLUE]);
    return p;
  endfunction

  // Returns once every queued pixel is taken and every expected result has arrived.
  task automatic wait_drained();
    while (pending_pixels.size() != 0 || s_axis_tvalid || expected_edges.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_reg(logic [sem_pkg::CFG_ADDR_W-1:0] addr,
                           logic [sem_pkg::CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_addr <= addr;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (addr == sem_pkg::REG_FRAME_WIDTH)
      width_reg = value[sem_pkg::FW_W-1:0];
    else
      height_reg = value[sem_pkg::FH_W-1:0];
  endtask

  // Waits for the block to go idle, then programs the frame size. Bits above the
  // width field carry random junk that the block must drop.
  task automatic setup_frame(int fw, int fh);
    logic [sem_pkg::CFG_DATA_W-1:0] wdata;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    wdata = sem_pkg::CFG_DATA_W'($urandom);
    wdata[sem_pkg::FW_W-1:0] = sem_pkg::FW_W'(fw);
    write_reg(sem_pkg::REG_FRAME_WIDTH, wdata);
    write_reg(sem_pkg::REG_FRAME_HEIGHT, sem_pkg::CFG_DATA_W'(fh));
    cur_w = (width_reg < 3) ? 3 : (width_reg > LINE_DEPTH) ? LINE_DEPTH : width_reg;
    cur_h = (height_reg < 3) ? 3 : height_reg;
  endtask

  // Queues rows of the current frame; pause_at >= 0 drains the block mid-frame.
  task automatic queue_pixels(style_t style, int rows, int pause_at);
    int x, y, n;
    n = 0;
    tone_base = $urandom_range(40, 215);
    slope_x   = int'($urandom_range(0, 48)) - 24;
    slope_y   = int'($urandom_range(0, 48)) - 24;
    for (y = 0; y < rows; y++) begin
      for (x = 0; x < cur_w; x++) begin
        if (n == pause_at) wait_drained();
        pending_pixels.push_back(make_pixel(style, x, y));
        n++;
      end
    end
  endtask

  // Pixel driver: offers the next queued pixel, with random gaps.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) compute_edge_pixel(s_axis_tdata);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_pixels.size() != 0 &&
            (no_idle || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= pending_pixels.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each transaction against the oldest expectation and
  // throttles tready, including the long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_edge = {m_axis_tlast, m_axis_tdata};
        if (expected_edges.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, got_edge);
          mismatches++;
        end else begin
          want_edge = expected_edges.pop_front();
          if (got_edge.red !== want_edge.red)
            flag_mismatch("edge_red", want_edge.red, got_edge.red);
          if (got_edge.green !== want_edge.green)
            flag_mismatch("edge_green", want_edge.green, got_edge.green);
          if (got_edge.blue !== want_edge.blue)
            flag_mismatch("edge_blue", want_edge.blue, got_edge.blue);
          if (got_edge.done !== want_edge.done)
            flag_mismatch("frame_done", want_edge.done, got_edge.done);
        end
      end
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left    <= stall_left - 1;
      end else begin
        m_axis_tready <= no_idle || ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
    end
  end

  // Watchdog: ends the run when neither bus moves for too long.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
      $display("** sobel_edge_magnitude_rgb_top: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus sequence.
  initial begin
    int     frame_no, random_pixels, fw, fh, pick;
    style_t style;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed: undersized registers clamp to 3x3; full-scale row and column edges.
    setup_frame(1, 2);
    queue_pixels(STYLE_ROWS, cur_h, -1);
    setup_frame(3, 0);
    queue_pixels(STYLE_COLS, cur_h, -1);

    // Random frames, mostly small.
    frame_no = 0;
    random_pixels = 0;
    while (random_pixels < RANDOM_PIXELS) begin
      pick = $urandom_range(0, 99);
      fw = (pick < 10) ? $urandom_range(0, 2) :
           (pick < 20) ? $urandom_range(13, 48) : $urandom_range(3, 12);
      pick = $urandom_range(0, 99);
      fh = (pick < 10) ? $urandom_range(0, 2) :
           (pick < 20) ? $urandom_range(9, 24) : $urandom_range(3, 8);
      if (frame_no == 3) begin
        fw = 16;
        fh = 8;
      end
      case ($urandom_range(0, 2))
        0:       style = STYLE_NOISE;
        1:       style = STYLE_SMOOTH;
        default: style = STYLE_SPARSE;
      endcase
      setup_frame(fw, fh);
      // One frame meets a receiver that holds off long enough to back up the input.
      if (frame_no == 3) stall_left <= HOLD_CYCLES;
      queue_pixels(style, cur_h, (frame_no == 6) ? cur_w * cur_h / 2 : -1);
      random_pixels += cur_w * cur_h;
      frame_no++;
    end

    // Tallest frame setting at full rate; only its top rows are sent.
    setup_frame(3, 65535);
    no_idle = 1'b1;
    queue_pixels(STYLE_NOISE, 100, -1);

    wait_drained();
    no_idle = 1'b0;
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("** sobel_edge_magnitude_rgb_top: PASSED **");
    else
      $display("** sobel_edge_magnitude_rgb_top: FAILED **");
    $finish;
  end

endmodule
